// File: sv/rm2q_pkg.sv
package rm2q_pkg;

  // Width of every matrix entry and signed quaternion component
  localparam int DATA_W = 16;

  // Largest magnitude a component may carry
  localparam logic [DATA_W-2:0] MAG_MAX = '1;

  // Lanes worked side by side: w, x, y, z
  localparam int LANES = 4;
  localparam int LANE_W = 0;
  localparam int LANE_X = 1;
  localparam int LANE_Y = 2;
  localparam int LANE_Z = 3;

  typedef struct packed {
    logic signed [DATA_W-1:0] r00;
    logic signed [DATA_W-1:0] r01;
    logic signed [DATA_W-1:0] r02;
    logic signed [DATA_W-1:0] r10;
    logic signed [DATA_W-1:0] r11;
    logic signed [DATA_W-1:0] r12;
    logic signed [DATA_W-1:0] r20;
    logic signed [DATA_W-1:0] r21;
    logic signed [DATA_W-1:0] r22;
  } matrix_t;

  typedef struct packed {
    logic        [DATA_W-2:0] quat_w;
    logic signed [DATA_W-1:0] quat_x;
    logic signed [DATA_W-1:0] quat_y;
    logic signed [DATA_W-1:0] quat_z;
  } quat_t;

  // Control that rides along the pipeline with each item
  typedef struct packed {
    logic       valid;
    logic [2:0] neg;  // x, y, z take a negative sign
  } ctl_t;

endpackage

// File: sv/rotation_matrix_to_quaternion_top.sv
// Rotation matrix to unit quaternion, Q2.14 fixed point.
//
// Input channel in_valid / in_stall / in_data carries the nine matrix entries;
// result channel out_valid / out_stall / out_data carries (w, x, y, z).
// A transfer happens on a rising edge with valid high and stall low.
// Each component magnitude is the truncated root of the clamped diagonal sum,
// saturated to the format limit; x, y, z take the sign of their off-diagonal
// difference (zero difference is positive).
//
// An item passes from the input transfer to out_valid through the sum register,
// which loads on the transfer edge, then a chain of QW root cells that resolve
// one root bit each for all four components, then the output register. QW is
// half the radicand width, rounded up. Throughput is one transfer per cycle
// while the chain is not held: every cell takes a new item each cycle it advances.
//
// Reset clears all valid flags; nothing is pending after it. When the receiver
// stalls a waiting result, the whole chain holds and in_stall rises in the
// same cycle; no item is dropped or repeated.
module rotation_matrix_to_quaternion_top
  import rm2q_pkg::*;
#(
  parameter int FRAC_BITS = 14
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  input  matrix_t in_data,
  output logic    out_valid,
  input  logic    out_stall,
  output quat_t   out_data
);

  localparam int SW   = ((DATA_W > FRAC_BITS + 1) ? DATA_W : FRAC_BITS + 1) + 3;
  localparam int RW   = SW + FRAC_BITS - 2;
  localparam int QW   = (RW + 1) / 2;
  localparam int RADW = 2 * QW;
  localparam int CW   = QW + DATA_W;

  logic adv;
  ctl_t ctl [QW+1];
  logic [LANES-1:0][RADW-1:0] rad  [QW+1];
  logic [LANES-1:0][QW:0]     rem  [QW+1];
  logic [LANES-1:0][QW-1:0]   root [QW+1];
  logic [DATA_W-2:0] mag [LANES];
  quat_t out_nxt;
  logic  out_valid_r;
  quat_t out_data_r;

  // Hold the whole chain while a result waits on a stalled receiver
  assign adv      = !(out_valid_r && out_stall);
  assign in_stall = !adv;

  rm2q_front #(
    .FRAC_BITS (FRAC_BITS),
    .RADW      (RADW)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_valid (in_valid),
    .in_data  (in_data),
    .ctl_o    (ctl[0]),
    .rad_o    (rad[0])
  );

  assign rem[0]  = '0;
  assign root[0] = '0;

  // Chain of root cells, most significant root bit first
  for (genvar k = 0; k < QW; k++) begin : g_cell
    rm2q_sqrt_cell #(
      .QW (QW)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .adv    (adv),
      .ctl_i  (ctl[k]),
      .rad_i  (rad[k]),
      .rem_i  (rem[k]),
      .root_i (root[k]),
      .ctl_o  (ctl[k+1]),
      .rad_o  (rad[k+1]),
      .rem_o  (rem[k+1]),
      .root_o (root[k+1])
    );
  end

  // Saturate the magnitudes and apply the signs
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      if (CW'(root[QW][l]) > CW'(MAG_MAX)) begin
        mag[l] = MAG_MAX;
      end else begin
        mag[l] = (DATA_W-1)'(CW'(root[QW][l]));
      end
    end
    out_nxt.quat_w = mag[LANE_W];
    out_nxt.quat_x = ctl[QW].neg[0] ? -{1'b0, mag[LANE_X]} : {1'b0, mag[LANE_X]};
    out_nxt.quat_y = ctl[QW].neg[1] ? -{1'b0, mag[LANE_Y]} : {1'b0, mag[LANE_Y]};
    out_nxt.quat_z = ctl[QW].neg[2] ? -{1'b0, mag[LANE_Z]} : {1'b0, mag[LANE_Z]};
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= ctl[QW].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A stalled result must freeze the input side
  a_stall_backs_up: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |-> in_stall)
    else $error("input taken while result stalled");

  // An accepted item enters the first stage
  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> ctl[0].valid)
    else $error("accepted item lost at first stage");

  // Saturation keeps signed components off the most negative code
  a_no_min_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.quat_x != {1'b1, {(DATA_W-1){1'b0}}}) &&
                  (out_data.quat_y != {1'b1, {(DATA_W-1){1'b0}}}) &&
                  (out_data.quat_z != {1'b1, {(DATA_W-1){1'b0}}}))
    else $error("component beyond saturation limit");

endmodule

// File: sv/rm2q_front.sv
module rm2q_front
  import rm2q_pkg::*;
#(
  parameter int FRAC_BITS = 14,
  parameter int RADW = 30
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        adv,
  input  logic                        in_valid,
  input  matrix_t                     in_data,
  output ctl_t                        ctl_o,
  output logic [LANES-1:0][RADW-1:0]  rad_o
);

  localparam int SW = ((DATA_W > FRAC_BITS + 1) ? DATA_W : FRAC_BITS + 1) + 3;
  localparam logic signed [SW-1:0] ONE = SW'(2 ** FRAC_BITS);

  logic signed [SW-1:0] a00, a11, a22;
  logic signed [SW-1:0] sum [LANES];
  logic signed [DATA_W:0] dx, dy, dz;
  logic [LANES-1:0][RADW-1:0] rad_nxt;
  ctl_t ctl_nxt;
  ctl_t ctl_r;
  logic [LANES-1:0][RADW-1:0] rad_r;

  // Widen the diagonal and form the four sign patterns
  assign a00 = SW'(in_data.r00);
  assign a11 = SW'(in_data.r11);
  assign a22 = SW'(in_data.r22);

  assign sum[LANE_W] = ONE + a00 + a11 + a22;
  assign sum[LANE_X] = ONE + a00 - a11 - a22;
  assign sum[LANE_Y] = ONE - a00 + a11 - a22;
  assign sum[LANE_Z] = ONE - a00 - a11 + a22;

  // Clamp at zero and scale into the root's radicand
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      if (sum[l][SW-1] || (sum[l] == '0)) begin
        rad_nxt[l] = '0;
      end else begin
        rad_nxt[l] = RADW'($unsigned(sum[l])) << (FRAC_BITS - 2);
      end
    end
  end

  // Off-diagonal differences; zero counts as positive
  assign dx = (DATA_W+1)'(in_data.r21) - (DATA_W+1)'(in_data.r12);
  assign dy = (DATA_W+1)'(in_data.r02) - (DATA_W+1)'(in_data.r20);
  assign dz = (DATA_W+1)'(in_data.r10) - (DATA_W+1)'(in_data.r01);

  assign ctl_nxt.valid = in_valid;
  assign ctl_nxt.neg   = {dz[DATA_W], dy[DATA_W], dx[DATA_W]};

  // Advance the stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (adv) begin
      ctl_r <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rad_r <= rad_nxt;
    end
  end

  assign ctl_o = ctl_r;
  assign rad_o = rad_r;

endmodule

// File: sv/rm2q_sqrt_cell.sv
module rm2q_sqrt_cell
  import rm2q_pkg::*;
#(
  parameter int QW = 15
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          adv,
  input  ctl_t                          ctl_i,
  input  logic [LANES-1:0][2*QW-1:0]    rad_i,
  input  logic [LANES-1:0][QW:0]        rem_i,
  input  logic [LANES-1:0][QW-1:0]      root_i,
  output ctl_t                          ctl_o,
  output logic [LANES-1:0][2*QW-1:0]    rad_o,
  output logic [LANES-1:0][QW:0]        rem_o,
  output logic [LANES-1:0][QW-1:0]      root_o
);

  localparam int RADW = 2 * QW;

  logic [QW+2:0] cand  [LANES];
  logic [QW+2:0] trial [LANES];
  logic [QW+2:0] diff  [LANES];
  logic [LANES-1:0][RADW-1:0] rad_nxt;
  logic [LANES-1:0][QW:0]     rem_nxt;
  logic [LANES-1:0][QW-1:0]   root_nxt;
  ctl_t                       ctl_r;
  logic [LANES-1:0][RADW-1:0] rad_r;
  logic [LANES-1:0][QW:0]     rem_r;
  logic [LANES-1:0][QW-1:0]   root_r;

  // Resolve one root bit per lane: bring down two radicand bits, try 4*root+1
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      cand[l]    = {rem_i[l], rad_i[l][RADW-1 -: 2]};
      trial[l]   = {1'b0, root_i[l], 2'b01};
      diff[l]    = cand[l] - trial[l];
      rad_nxt[l] = {rad_i[l][RADW-3:0], 2'b00};
      if (cand[l] >= trial[l]) begin
        rem_nxt[l]  = diff[l][QW:0];
        root_nxt[l] = {root_i[l][QW-2:0], 1'b1};
      end else begin
        rem_nxt[l]  = cand[l][QW:0];
        root_nxt[l] = {root_i[l][QW-2:0], 1'b0};
      end
    end
  end

  // Hand the partial result to the next cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (adv) begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rad_r  <= rad_nxt;
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
  end

  assign ctl_o  = ctl_r;
  assign rad_o  = rad_r;
  assign rem_o  = rem_r;
  assign root_o = root_r;

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import rm2q_pkg::*;

  localparam int CLK_PERIOD = 12;
  localparam int FRAC_BITS = 14;
  localparam int Q_ONE = 1 << FRAC_BITS;
  localparam int S_MAX = 32767;
  localparam int S_MIN = -32768;
  localparam int RANDOM_MATRICES = 1130;
  localparam int TAIL_CYCLES = 40;
  localparam longint TIMEOUT_CYCLES = 400000;

  // Kinds of random matrix
  typedef enum int {
    GEN_ROTATION,
    GEN_NEAR_AXIS,
    GEN_RAW_BITS,
    GEN_CORNERS
  } gen_kind_t;

  // Predict each quaternion from its matrix and hold the expectations in order
  class quat_scoreboard;
    quat_t expected_q[$];
    int n_fail;
    int n_noted;
    int n_zero_w;
    int n_neg_parts;

    function longint unsigned floor_root(longint unsigned v);
      longint unsigned res;
      longint unsigned probe;
      res = 0;
      probe = 64'h1 << 62;
      while (probe > v) probe >>= 2;
      while (probe != 0) begin
        if (v >= res + probe) begin
          v -= res + probe;
          res = (res >> 1) + probe;
        end else begin
          res >>= 1;
        end
        probe >>= 2;
      end
      return res;
    endfunction

    // Half root of the clamped diagonal sum, truncated and saturated
    function logic [DATA_W-2:0] lane_mag(int a, int b, int c);
      longint s;
      longint unsigned r;
      s = longint'(Q_ONE) + a + b + c;
      if (s <= 0) return '0;
      r = floor_root(longint'(unsigned'(s)) << (FRAC_BITS - 2));
      if (r > MAG_MAX) return MAG_MAX;
      return r[DATA_W-2:0];
    endfunction

    // Negate the magnitude when the off-diagonal difference is below zero
    function logic signed [DATA_W-1:0] signed_part(logic [DATA_W-2:0] mag, int diff);
      logic [DATA_W-1:0] wide;
      wide = {1'b0, mag};
      if (diff < 0) return DATA_W'(0) - wide;
      return wide;
    endfunction

    function void note_matrix(matrix_t m);
      int a00, a01, a02, a10, a11, a12, a20, a21, a22;
      quat_t q;
      a00 = int'(m.r00); a01 = int'(m.r01); a02 = int'(m.r02);
      a10 = int'(m.r10); a11 = int'(m.r11); a12 = int'(m.r12);
      a20 = int'(m.r20); a21 = int'(m.r21); a22 = int'(m.r22);
      q.quat_w = lane_mag(a00, a11, a22);
      q.quat_x = signed_part(lane_mag(a00, -a11, -a22), a21 - a12);
      q.quat_y = signed_part(lane_mag(-a00, a11, -a22), a02 - a20);
      q.quat_z = signed_part(lane_mag(-a00, -a11, a22), a10 - a01);
      n_noted++;
      if (q.quat_w == 0) n_zero_w++;
      n_neg_parts += int'(q.quat_x < 0) + int'(q.quat_y < 0) + int'(q.quat_z < 0);
      expected_q.push_back(q);
    endfunction

    function void check_quat(quat_t got);
      quat_t want;
      bit bad;
      bad = 0;
      if (expected_q.size() == 0) begin
        $error("result transfer with no expected quaternion pending");
        n_fail++;
        return;
      end
      want = expected_q.pop_front();
      if (got.quat_w !== want.quat_w) begin
        $error("quat_w mismatch: expected %0d, actual %0d", want.quat_w, got.quat_w);
        bad = 1;
      end
      if (got.quat_x !== want.quat_x) begin
        $error("quat_x mismatch: expected %0d, actual %0d", want.quat_x, got.quat_x);
        bad = 1;
      end
      if (got.quat_y !== want.quat_y) begin
        $error("quat_y mismatch: expected %0d, actual %0d", want.quat_y, got.quat_y);
        bad = 1;
      end
      if (got.quat_z !== want.quat_z) begin
        $error("quat_z mismatch: expected %0d, actual %0d", want.quat_z, got.quat_z);
        bad = 1;
      end
      if (bad) n_fail++;
    endfunction
  endclass

  logic    clk = 1'b0;
  logic    rst_n = 1'b0;
  logic    in_valid = 1'b0;
  logic    in_stall;
  matrix_t in_data = '0;
  logic    out_valid;
  logic    out_stall = 1'b0;
  quat_t   out_data;

  bit in_burst = 1'b0;
  bit out_burst = 1'b0;

  quat_scoreboard sb = new();

  rotation_matrix_to_quaternion_top #(
    .FRAC_BITS(FRAC_BITS)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Abort a hung run
  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic matrix_t mat9(int a00, int a01, int a02, int a10, int a11, int a12,
                                   int a20, int a21, int a22);
    matrix_t m;
    m.r00 = DATA_W'(a00); m.r01 = DATA_W'(a01); m.r02 = DATA_W'(a02);
    m.r10 = DATA_W'(a10); m.r11 = DATA_W'(a11); m.r12 = DATA_W'(a12);
    m.r20 = DATA_W'(a20); m.r21 = DATA_W'(a21); m.r22 = DATA_W'(a22);
    return m;
  endfunction

  function automatic int to_fixed(real v);
    return $rtoi(v * real'(Q_ONE) + (v >= 0.0 ? 0.5 : -0.5));
  endfunction

  function automatic int pick_corner();
    case ($urandom_range(0, 8))
      0: return S_MIN;
      1: return S_MIN + 1;
      2: return -Q_ONE;
      3: return -1;
      4: return 0;
      5: return 1;
      6: return Q_ONE;
      7: return S_MAX - 1;
      default: return S_MAX;
    endcase
  endfunction

  // Build a rotation from a random quaternion; near_axis zeroes some parts
  function automatic matrix_t rotation_matrix(bit near_axis);
    real w, x, y, z, n;
    matrix_t m;
    w = real'(int'($urandom_range(0, 2000)) - 1000);
    x = real'(int'($urandom_range(0, 2000)) - 1000);
    y = real'(int'($urandom_range(0, 2000)) - 1000);
    z = real'(int'($urandom_range(0, 2000)) - 1000);
    if (near_axis) begin
      case ($urandom_range(0, 5))
        0: w = 0.0;
        1: x = 0.0;
        2: y = 0.0;
        3: z = 0.0;
        4: begin w = 0.0; x = 0.0; end
        default: begin y = 0.0; z = 0.0; end
      endcase
    end
    n = $sqrt(w * w + x * x + y * y + z * z);
    if (n < 1.0) begin
      w = 1.0; x = 0.0; y = 0.0; z = 0.0; n = 1.0;
    end
    w = w / n; x = x / n; y = y / n; z = z / n;
    m = mat9(to_fixed(1.0 - 2.0 * (y * y + z * z)), to_fixed(2.0 * (x * y - z * w)),
             to_fixed(2.0 * (x * z + y * w)), to_fixed(2.0 * (x * y + z * w)),
             to_fixed(1.0 - 2.0 * (x * x + z * z)), to_fixed(2.0 * (y * z - x * w)),
             to_fixed(2.0 * (x * z - y * w)), to_fixed(2.0 * (y * z + x * w)),
             to_fixed(1.0 - 2.0 * (x * x + y * y)));
    // Jitter a few LSBs so sums straddle zero and roots straddle integers
    if ($urandom_range(0, 1) == 1) begin
      for (int i = 0; i < 9; i++)
        m[i*DATA_W +: DATA_W] = m[i*DATA_W +: DATA_W] + DATA_W'(int'($urandom_range(0, 6)) - 3);
    end
    return m;
  endfunction

  function automatic matrix_t random_matrix();
    matrix_t m;
    int roll;
    gen_kind_t kind;
    roll = $urandom_range(0, 99);
    if (roll < 55) kind = GEN_ROTATION;
    else if (roll < 70) kind = GEN_NEAR_AXIS;
    else if (roll < 85) kind = GEN_RAW_BITS;
    else kind = GEN_CORNERS;
    case (kind)
      GEN_ROTATION:  m = rotation_matrix(1'b0);
      GEN_NEAR_AXIS: m = rotation_matrix(1'b1);
      GEN_RAW_BITS: begin
        for (int i = 0; i < 9; i++) m[i*DATA_W +: DATA_W] = DATA_W'($urandom);
      end
      default: begin
        for (int i = 0; i < 9; i++) m[i*DATA_W +: DATA_W] = DATA_W'(pick_corner());
      end
    endcase
    return m;
  endfunction

  // Drive one matrix after a random idle gap, which may be empty, and hold it until the transfer
  task automatic push_matrix(matrix_t m);
    int gap;
    gap = in_burst ? 0 : $urandom_range(0, 9);
    if ($urandom_range(0, 39) == 0) in_burst = !in_burst;
    repeat (gap) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= m;
    do @(posedge clk); while (in_stall);
    sb.note_matrix(m);
  endtask

  // Result side: stall at random, then check each transfer
  initial begin
    int gap;
    wait (rst_n);
    @(posedge clk);
    forever begin
      gap = out_burst ? 0 : $urandom_range(0, 9);
      if ($urandom_range(0, 39) == 0) out_burst = !out_burst;
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
      sb.check_quat(out_data);
    end
  end

  initial begin
    int n_directed;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Identity, zero and full-scale matrices
    push_matrix(mat9(Q_ONE, 0, 0, 0, Q_ONE, 0, 0, 0, Q_ONE));
    push_matrix(mat9(0, 0, 0, 0, 0, 0, 0, 0, 0));
    push_matrix(mat9(S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX));
    push_matrix(mat9(S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN));
    push_matrix(mat9(S_MAX, S_MIN, S_MIN, S_MIN, S_MAX, S_MIN, S_MIN, S_MIN, S_MAX));
    push_matrix(mat9(S_MIN, S_MAX, S_MAX, S_MAX, S_MIN, S_MAX, S_MAX, S_MAX, S_MIN));
    // Half turns about each axis, then the negated identity: scalar part clamps to zero
    push_matrix(mat9(Q_ONE, 0, 0, 0, -Q_ONE, 0, 0, 0, -Q_ONE));
    push_matrix(mat9(-Q_ONE, 0, 0, 0, Q_ONE, 0, 0, 0, -Q_ONE));
    push_matrix(mat9(-Q_ONE, 0, 0, 0, -Q_ONE, 0, 0, 0, Q_ONE));
    push_matrix(mat9(-Q_ONE, 0, 0, 0, -Q_ONE, 0, 0, 0, -Q_ONE));
    // Quarter turns, positive and negative signs
    push_matrix(mat9(Q_ONE, 0, 0, 0, 0, -Q_ONE, 0, Q_ONE, 0));
    push_matrix(mat9(0, 0, -Q_ONE, 0, Q_ONE, 0, Q_ONE, 0, 0));
    push_matrix(mat9(0, -Q_ONE, 0, Q_ONE, 0, 0, 0, 0, Q_ONE));
    // Largest sums per vector lane, with extreme differences of both signs
    push_matrix(mat9(S_MAX, 0, 0, 0, S_MIN, S_MIN, 0, S_MAX, S_MIN));
    push_matrix(mat9(S_MAX, 0, 0, 0, S_MIN, S_MAX, 0, S_MIN, S_MIN));
    push_matrix(mat9(S_MIN, 0, S_MAX, 0, S_MAX, 0, S_MIN, 0, S_MIN));
    push_matrix(mat9(S_MIN, 0, S_MIN, 0, S_MAX, 0, S_MAX, 0, S_MIN));
    push_matrix(mat9(S_MIN, S_MIN, 0, S_MAX, S_MIN, 0, 0, 0, S_MAX));
    push_matrix(mat9(S_MIN, S_MAX, 0, S_MIN, S_MIN, 0, 0, 0, S_MAX));
    // Zero differences keep a positive sign
    push_matrix(mat9(8192, 5000, -7000, 5000, 8192, 3000, -7000, 3000, 8192));
    // Zero magnitude with a negative difference stays zero
    push_matrix(mat9(Q_ONE, 50, -30, -50, Q_ONE, 100, 30, -100, Q_ONE));
    // Scalar sum at zero, one above, one below
    push_matrix(mat9(0, 0, 0, 0, 0, 0, 0, 0, -Q_ONE));
    push_matrix(mat9(0, 0, 0, 0, 0, 0, 0, 0, -Q_ONE + 1));
    push_matrix(mat9(0, 0, 0, 0, 0, 0, 0, 0, -Q_ONE - 1));
    n_directed = sb.n_noted;

    for (int i = 0; i < RANDOM_MATRICES; i++) push_matrix(random_matrix());
    in_valid <= 1'b0;

    // Drain, then watch for stray results
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Converted %0d matrices (%0d directed, rest random rotations and raw patterns)",
             sb.n_noted, n_directed);
    $display("Scalar part zero in %0d results; %0d vector parts came out negative",
             sb.n_zero_w, sb.n_neg_parts);
    if (sb.n_fail == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/rm2q_pkg.sv
sv/rm2q_front.sv
sv/rm2q_sqrt_cell.sv
sv/rotation_matrix_to_quaternion_top.sv
tb/testbench.sv
